/* rtl/core/lgtr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lgtr_pkg;
  localparam int unsigned TOPIC_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOPICS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY_DOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_TOP = 2'd2;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [11:0] doc_index;
    logic [12:0] word_index;
    logic [4:0]  current_topic;
    logic [15:0] random_fraction;
  } token_t;

  typedef struct packed {
    logic [TOPIC_W-1:0]  new_topic;
    logic [STATUS_W-1:0] status;
  } result_t;
endpackage
`default_nettype wire

/* rtl/core/lgtr_token_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lgtr_token_if;
  logic valid;
  logic ready;
  logic        operation;
  logic [11:0] doc_index;
  logic [12:0] word_index;
  logic [4:0]  current_topic;
  logic [15:0] random_fraction;
  modport source (output valid, operation, doc_index, word_index, current_topic,
    random_fraction, input ready);
  modport sink (input valid, operation, doc_index, word_index, current_topic,
    random_fraction, output ready);
endinterface
`default_nettype wire

/* rtl/core/lgtr_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lgtr_result_if;
  logic valid;
  logic ready;
  logic [4:0] new_topic;
  logic [1:0] status;
  modport source (output valid, new_topic, status, input ready);
  modport sink (input valid, new_topic, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/lgtr_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lgtr_cfg_if;
  logic valid;
  logic ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/lgtr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lgtr_front (
  input  wire logic clk,
  input  wire logic rst,
  lgtr_token_if.sink tok,
  output lgtr_pkg::token_t q_data,
  output logic q_valid,
  input  wire logic q_pop
);
  lgtr_pkg::token_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;
  assign tok.ready = (cnt != 2'd2);
  assign push = tok.valid && tok.ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = mem[rp];
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{tok.operation, tok.doc_index, tok.word_index, tok.current_topic,
                   tok.random_fraction};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/lgtr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module lgtr_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic busy,
  output logic [63:0] quo
);
  logic [63:0] r, d;
  logic [6:0] k;
  logic [64:0] rs;
  assign rs = {r, quo[63]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k <= '0;
    end else if (start) begin
      busy <= 1'b1;
      k <= 7'd0;
      quo <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      if (rs >= {1'b0, d}) begin
        r <= 64'(rs - {1'b0, d});
        quo <= {quo[62:0], 1'b1};
      end else begin
        r <= rs[63:0];
        quo <= {quo[62:0], 1'b0};
      end
      k <= k + 7'd1;
      if (k == 7'd63) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/lgtr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lgtr_back #(
  parameter int DOCS = 4096,
  parameter int TOPICS = 32,
  parameter int WORDS = 8192,
  parameter int COUNT_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire lgtr_pkg::token_t q_data,
  input  wire logic q_valid,
  output logic q_pop,
  input  wire logic [5:0] topics_in_use,
  input  wire logic [13:0] words_in_use,
  input  wire logic [15:0] alpha_prior,
  input  wire logic [15:0] beta_prior,
  output logic clearing,
  lgtr_result_if.source res
);
  localparam int DW = (DOCS > 1) ? $clog2(DOCS) : 1;
  localparam int TW = $clog2(TOPICS);
  localparam int WW = $clog2(WORDS);
  localparam int DTD = DOCS * TOPICS;
  localparam int TWD = TOPICS * WORDS;
  localparam int DTA = $clog2(DTD);
  localparam int TWA = $clog2(TWD);
  localparam int CLR_N = (DTD > TWD) ? DTD : TWD;
  localparam int CW = $clog2(CLR_N) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CHK = 4'd3,
    S_TCHK = 4'd4, S_WRD = 4'd5, S_WDIV = 4'd6, S_WMUL = 4'd7, S_THR = 4'd8,
    S_SRD = 4'd9, S_SCMP = 4'd10, S_UPD = 4'd11, S_UPD2 = 4'd12, S_OUT = 4'd13,
    S_WMUL2 = 4'd14, S_WUPD = 4'd15;

  logic [COUNT_BITS-1:0] dt_mem [DTD];
  logic [COUNT_BITS-1:0] tw_mem [TWD];
  logic [COUNT_BITS-1:0] dtot_mem [DOCS];
  logic [COUNT_BITS-1:0] ttot [TOPICS];
  logic [47:0] wts [TOPICS];

  logic [3:0] state;
  logic [CW-1:0] clr;
  lgtr_pkg::token_t tk;
  logic [DW-1:0] doc;
  logic [DW-1:0] dtot_wa;
  logic [WW-1:0] word;
  logic [TW-1:0] cur, t, pick;
  logic [TW:0] tmax;
  logic [DTA-1:0] dt_ra, dt_wa;
  logic [TWA-1:0] tw_ra, tw_wa;
  logic [COUNT_BITS-1:0] dt_rd, tw_rd, dtot_rd, dt_wd, tw_wd, dtot_wd;
  logic dt_we, tw_we, dtot_we;
  logic [COUNT_BITS-1:0] dt_v, tw_v, tot_v;
  logic [63:0] sum, run, thr, prod;
  logic [47:0] av;
  logic [23:0] rv;
  logic div_start, div_busy;
  logic [63:0] div_num, div_den, div_quo;
  logic [31:0] bw;
  logic [COUNT_BITS-1:0] tot_t;
  logic [4:0] res_topic, out_topic;
  logic [1:0] res_status, out_status;
  logic res_valid;

  assign clearing = (state == S_CLR);
  assign doc = DW'(tk.doc_index % DOCS);
  assign word = WW'(tk.word_index % WORDS);
  assign cur = TW'(tk.current_topic % TOPICS);
  assign bw = beta_prior * words_in_use;
  assign tot_t = (t == cur) ? ((ttot[t] == '0) ? '0 : ttot[t] - 1'b1) : ttot[t];
  assign tw_v = (t == cur) ? ((tw_rd == '0) ? '0 : tw_rd - 1'b1) : tw_rd;
  assign tot_v = tot_t;
  assign res.valid = res_valid;
  assign res.new_topic = out_topic;
  assign res.status = out_status;
  assign q_pop = (state == S_IDLE) && q_valid;

  lgtr_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo));

  always_ff @(posedge clk) begin
    dt_rd <= dt_mem[dt_ra];
    tw_rd <= tw_mem[tw_ra];
    dtot_rd <= dtot_mem[doc];
    if (dt_we) dt_mem[dt_wa] <= dt_wd;
    if (tw_we) tw_mem[tw_wa] <= tw_wd;
    if (dtot_we) dtot_mem[dtot_wa] <= dtot_wd;
  end

  always_comb begin
    dt_ra = DTA'(doc * TOPICS + t);
    tw_ra = TWA'(t * WORDS + word);
    dt_we = 1'b0; tw_we = 1'b0; dtot_we = 1'b0;
    dt_wa = dt_ra; tw_wa = tw_ra; dtot_wa = doc;
    dt_wd = '0; tw_wd = '0; dtot_wd = '0;
    div_start = 1'b0;
    div_num = ((64'(tw_v) << 16) + 64'(beta_prior)) << 16;
    div_den = (64'(tot_v) << 16) + 64'(bw);
    if (div_den == '0) div_den = 64'd1;
    unique case (state)
      S_CLR: begin
        dt_we = (clr < CW'(DTD)); tw_we = (clr < CW'(TWD));
        dtot_we = (clr < CW'(DOCS));
        dt_wa = DTA'(clr); tw_wa = TWA'(clr); dtot_wa = DW'(clr);
      end
      S_WDIV: div_start = !div_busy && (prod == '0);
      S_UPD: begin
        if (tk.operation == lgtr_pkg::OP_LOAD) begin
          dt_we = 1'b1; tw_we = 1'b1; dtot_we = 1'b1;
          dt_wd = (dt_rd == CMAX) ? CMAX : dt_rd + 1'b1;
          tw_wd = (tw_rd == CMAX) ? CMAX : tw_rd + 1'b1;
          dtot_wd = (dtot_rd == CMAX) ? CMAX : dtot_rd + 1'b1;
        end else begin
          dt_we = 1'b1; tw_we = 1'b1;
          dt_wd = (dt_rd == '0) ? '0 : dt_rd - 1'b1;
          tw_wd = (tw_rd == '0) ? '0 : tw_rd - 1'b1;
        end
      end
      S_UPD2: begin
        dt_we = 1'b1; tw_we = 1'b1;
        dt_wd = (dt_rd == CMAX) ? CMAX : dt_rd + 1'b1;
        tw_wd = (tw_rd == CMAX) ? CMAX : tw_rd + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < TOPICS; i++) ttot[i] <= '0;
    end else begin
      if (res_valid && res.ready && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == CW'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          tk <= q_data;
          state <= S_RD;
          tmax <= (topics_in_use == 6'd0) ? (TW+1)'(1) :
                  (32'(topics_in_use) > TOPICS) ? (TW+1)'(TOPICS) : (TW+1)'(topics_in_use);
        end
        S_RD: begin
          t <= cur;
          state <= S_CHK;
        end
        S_CHK: begin
          if (tk.operation == lgtr_pkg::OP_LOAD) begin
            state <= S_UPD;
          end else if (dtot_rd == '0) begin
            res_topic <= tk.current_topic; res_status <= lgtr_pkg::ST_EMPTY_DOC;
            state <= S_OUT;
          end else begin
            t <= '0;
            state <= S_TCHK;
          end
        end
        S_TCHK: begin
          if (tot_t == '0) begin
            res_topic <= tk.current_topic; res_status <= lgtr_pkg::ST_EMPTY_TOP;
            state <= S_OUT;
          end else if ((TW+1)'(t) == tmax - 1'b1) begin
            t <= '0; sum <= '0; state <= S_WRD;
          end else t <= t + 1'b1;
        end
        S_WRD: begin
          state <= S_WDIV; prod <= '0;
        end
        S_WDIV: begin
          if (prod == '0 && !div_busy) begin
            dt_v <= (t == cur) ? ((dt_rd == '0) ? '0 : dt_rd - 1'b1) : dt_rd;
            prod <= 64'd1;
          end else if (!div_busy && prod == 64'd2) begin
            rv <= (div_quo > 64'hFFFFFF) ? 24'hFFFFFF : div_quo[23:0];
            av <= (48'(dt_v) << 16) + 48'(alpha_prior);
            state <= S_WMUL;
          end else if (prod == 64'd1) prod <= 64'd2;
        end
        S_WMUL: begin
          prod <= 64'(av[47:16]) * 64'(rv);
          state <= S_WMUL2;
        end
        S_WMUL2: begin
          wts[t] <= (prod + 64'((64'(av[15:0]) * 64'(rv)) >> 16) > 64'hFFFFFFFFFFFF) ?
            48'hFFFFFFFFFFFF : 48'(prod + 64'((64'(av[15:0]) * 64'(rv)) >> 16));
          sum <= sum + ((prod + 64'((64'(av[15:0]) * 64'(rv)) >> 16) > 64'hFFFFFFFFFFFF) ?
            64'hFFFFFFFFFFFF : prod + 64'((64'(av[15:0]) * 64'(rv)) >> 16));
          if ((TW+1)'(t) == tmax - 1'b1) state <= S_THR;
          else begin t <= t + 1'b1; state <= S_WRD; end
        end
        S_THR: begin
          thr <= (sum >> 16) * 64'(tk.random_fraction) +
                 (((sum & 64'hFFFF) * 64'(tk.random_fraction)) >> 16);
          run <= '0; t <= '0; pick <= TW'(tmax - 1'b1);
          state <= S_SRD;
        end
        S_SRD: begin
          if (thr < run + 64'(wts[t])) begin
            pick <= t; t <= cur; state <= S_SCMP;
          end else if ((TW+1)'(t) == tmax - 1'b1) begin
            t <= cur; state <= S_SCMP;
          end else begin run <= run + 64'(wts[t]); t <= t + 1'b1; end
        end
        S_SCMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (tk.operation == lgtr_pkg::OP_LOAD) begin
            ttot[cur] <= (ttot[cur] == CMAX) ? CMAX : ttot[cur] + 1'b1;
            res_topic <= tk.current_topic; res_status <= lgtr_pkg::ST_OK;
            state <= S_OUT;
          end else begin
            ttot[cur] <= (ttot[cur] == '0) ? '0 : ttot[cur] - 1'b1;
            t <= pick; state <= S_WUPD;
          end
        end
        S_WUPD: begin
          state <= S_UPD2;
        end
        S_UPD2: begin
          ttot[pick] <= (ttot[pick] == CMAX) ? CMAX : ttot[pick] + 1'b1;
          res_topic <= 5'(pick); res_status <= lgtr_pkg::ST_OK;
          state <= S_OUT;
        end
        S_OUT: if (!res_valid || res.ready) begin
          res_valid <= 1'b1; out_topic <= res_topic; out_status <= res_status;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/lda_gibbs_token_resampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// tok     | in  | operation, doc_index, word_index, current_topic, random_fraction
// res     | out | new_topic, status
// cfg     | in  | index, data
// Load: the token goes through read, check and count update to the result. Resample:
// per topic in use, an empty-topic check and a weight through the 64-bit bit-serial
// divider (one quotient bit a cycle), then a search for the sampled topic. After reset
// a clearing pass over TOPICS*max(DOCS,WORDS) addresses runs before the back takes
// tokens. A two-entry queue absorbs input while the back works; a waiting result holds
// the back in its last state.
module lda_gibbs_token_resampler #(
  parameter int DOCS = 4096,
  parameter int TOPICS = 32,
  parameter int WORDS = 8192,
  parameter int COUNT_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  lgtr_token_if.sink tok,
  lgtr_result_if.source res,
  lgtr_cfg_if.sink cfg
);
  logic [5:0] topics_in_use;
  logic [13:0] words_in_use;
  logic [15:0] alpha_prior, beta_prior;
  lgtr_pkg::token_t q_data;
  logic q_valid, q_pop, clearing;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      topics_in_use <= 6'd20; words_in_use <= 14'd5000;
      alpha_prior <= 16'd6554; beta_prior <= 16'd655;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lgtr_pkg::REG_TOPICS: topics_in_use <= cfg.data[5:0];
        lgtr_pkg::REG_WORDS: words_in_use <= cfg.data[13:0];
        lgtr_pkg::REG_ALPHA: alpha_prior <= cfg.data;
        lgtr_pkg::REG_BETA: beta_prior <= cfg.data;
        default: ;
      endcase
    end
  end

  lgtr_front u_front (.clk, .rst, .tok, .q_data, .q_valid, .q_pop);

  lgtr_back #(.DOCS(DOCS), .TOPICS(TOPICS), .WORDS(WORDS), .COUNT_BITS(COUNT_BITS))
    u_back (.clk, .rst, .q_data, .q_valid(q_valid && !clearing), .q_pop,
      .topics_in_use, .words_in_use, .alpha_prior, .beta_prior, .clearing, .res);
endmodule
`default_nettype wire

/* tb/lda_gibbs_token_resampler_test.sv */
`timescale 1ns / 1ps
module lda_gibbs_token_resampler_test;
  localparam int NDOCS = 4096;
  localparam int NTOPICS = 32;
  localparam int NWORDS = 8192;
  localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;
  localparam longint unsigned RATIO_TOP = 64'hFFFFFF;
  localparam longint unsigned WEIGHT_TOP = 64'hFFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lgtr_token_if tok_if ();
  lgtr_result_if res_if ();
  lgtr_cfg_if cfg_if ();

  lda_gibbs_token_resampler DUT (
    .clk(clk),
    .rst(rst),
    .tok(tok_if.sink),
    .res(res_if.source),
    .cfg(cfg_if.sink)
  );

  always #6 clk = ~clk;

  // predictor state
  bit [23:0] doc_topic_cnt [NDOCS*NTOPICS];
  bit [23:0] topic_word_cnt [NTOPICS*NWORDS];
  bit [23:0] topic_tot [NTOPICS];
  bit [23:0] doc_tot [NDOCS];
  bit [5:0] topics_reg = 6'd20;
  bit [13:0] words_reg = 14'd5000;
  bit [15:0] alpha_reg = 16'd6554;
  bit [15:0] beta_reg = 16'd655;

  lgtr_pkg::result_t pending_results [$];
  int failures = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic bit [23:0] count_up(bit [23:0] v);
    return (v == COUNT_TOP) ? v : v + 24'd1;
  endfunction

  function automatic bit [23:0] count_down(bit [23:0] v);
    return (v == 24'd0) ? v : v - 24'd1;
  endfunction

  function automatic int active_topics();
    if (topics_reg == 0) return 1;
    if (topics_reg > NTOPICS) return NTOPICS;
    return int'(topics_reg);
  endfunction

  function automatic lgtr_pkg::result_t resample_token(lgtr_pkg::token_t t);
    lgtr_pkg::result_t r;
    int doc, word, cur, tn, pick;
    bit [23:0] dt_c, tw_c, tot_c, dt, tw, tot;
    longint unsigned a, b, d, q, w, total, thr, run, bw, frac;
    longint unsigned wt [NTOPICS];
    doc = int'(t.doc_index);
    word = int'(t.word_index);
    cur = int'(t.current_topic);
    frac = 64'(t.random_fraction);
    r.new_topic = t.current_topic;
    r.status = lgtr_pkg::ST_OK;
    if (t.operation == lgtr_pkg::OP_LOAD) begin
      doc_tot[doc] = count_up(doc_tot[doc]);
      topic_tot[cur] = count_up(topic_tot[cur]);
      doc_topic_cnt[doc*NTOPICS+cur] = count_up(doc_topic_cnt[doc*NTOPICS+cur]);
      topic_word_cnt[cur*NWORDS+word] = count_up(topic_word_cnt[cur*NWORDS+word]);
      return r;
    end
    tn = active_topics();
    if (doc_tot[doc] == 0) begin
      r.status = lgtr_pkg::ST_EMPTY_DOC;
      return r;
    end
    dt_c = count_down(doc_topic_cnt[doc*NTOPICS+cur]);
    tw_c = count_down(topic_word_cnt[cur*NWORDS+word]);
    tot_c = count_down(topic_tot[cur]);
    for (int i = 0; i < tn; i++) begin
      tot = (i == cur) ? tot_c : topic_tot[i];
      if (tot == 0) begin
        r.status = lgtr_pkg::ST_EMPTY_TOP;
        return r;
      end
    end
    bw = 64'(beta_reg) * 64'(words_reg);
    total = 0;
    for (int i = 0; i < tn; i++) begin
      dt = (i == cur) ? dt_c : doc_topic_cnt[doc*NTOPICS+i];
      tw = (i == cur) ? tw_c : topic_word_cnt[i*NWORDS+word];
      tot = (i == cur) ? tot_c : topic_tot[i];
      a = (64'(dt) << 16) + 64'(alpha_reg);
      b = (64'(tw) << 16) + 64'(beta_reg);
      d = (64'(tot) << 16) + bw;
      if (d == 0) d = 1;
      q = (b << 16) / d;
      if (q > RATIO_TOP) q = RATIO_TOP;
      w = (a >> 16) * q + (((a & 64'hFFFF) * q) >> 16);
      if (w > WEIGHT_TOP) w = WEIGHT_TOP;
      wt[i] = w;
      total += w;
    end
    thr = (total >> 16) * frac + (((total & 64'hFFFF) * frac) >> 16);
    pick = tn - 1;
    run = 0;
    for (int i = 0; i < tn; i++) begin
      run += wt[i];
      if (thr < run) begin
        pick = i;
        break;
      end
    end
    topic_tot[cur] = tot_c;
    doc_topic_cnt[doc*NTOPICS+cur] = dt_c;
    topic_word_cnt[cur*NWORDS+word] = tw_c;
    topic_tot[pick] = count_up(topic_tot[pick]);
    doc_topic_cnt[doc*NTOPICS+pick] = count_up(doc_topic_cnt[doc*NTOPICS+pick]);
    topic_word_cnt[pick*NWORDS+word] = count_up(topic_word_cnt[pick*NWORDS+word]);
    r.new_topic = pick[4:0];
    return r;
  endfunction

  task automatic send_token(lgtr_pkg::token_t t);
    if ($urandom_range(99) < send_idle) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    tok_if.valid <= 1'b1;
    tok_if.operation <= t.operation;
    tok_if.doc_index <= t.doc_index;
    tok_if.word_index <= t.word_index;
    tok_if.current_topic <= t.current_topic;
    tok_if.random_fraction <= t.random_fraction;
    do @(posedge clk); while (!tok_if.ready);
    pending_results.push_back(resample_token(t));
  endtask

  task automatic send_op(bit op, int doc, int word, int topic, int frac);
    lgtr_pkg::token_t t;
    t.operation = op;
    t.doc_index = 12'(doc);
    t.word_index = 13'(word);
    t.current_topic = 5'(topic);
    t.random_fraction = 16'(frac);
    send_token(t);
  endtask

  task automatic drain();
    tok_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      lgtr_pkg::REG_TOPICS: topics_reg = value[5:0];
      lgtr_pkg::REG_WORDS: words_reg = value[13:0];
      lgtr_pkg::REG_ALPHA: alpha_reg = value;
      default: beta_reg = value;
    endcase
  endtask

  task automatic set_regs(int tn, int words, int alpha, int beta);
    drain();
    write_reg(lgtr_pkg::REG_TOPICS, 16'(tn));
    write_reg(lgtr_pkg::REG_WORDS, 16'(words));
    write_reg(lgtr_pkg::REG_ALPHA, 16'(alpha));
    write_reg(lgtr_pkg::REG_BETA, 16'(beta));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic lgtr_pkg::token_t random_token();
    lgtr_pkg::token_t t;
    int tn;
    tn = active_topics();
    t.random_fraction = 16'($urandom_range(65535));
    if ($urandom_range(99) < 85) begin
      t.operation = ($urandom_range(99) < 60) ? lgtr_pkg::OP_RESAMPLE : lgtr_pkg::OP_LOAD;
      t.doc_index = 12'($urandom_range(15));
      t.word_index = 13'($urandom_range(31));
      t.current_topic = 5'($urandom_range(tn - 1));
      if ($urandom_range(99) < 5) t.current_topic = 5'($urandom_range(31));
    end else begin
      t.operation = 1'($urandom_range(1));
      t.doc_index = 12'($urandom_range(4095));
      t.word_index = 13'($urandom_range(8191));
      t.current_topic = 5'($urandom_range(31));
    end
    return t;
  endfunction

  task automatic run_random(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) send_token(random_token());
  endtask

  task automatic test_directed();
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 3, 100);
    send_op(lgtr_pkg::OP_LOAD, 5, 7, 3, 0);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 3, 100);
    set_regs(4, 5000, 6554, 655);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 3, 200);
    for (int i = 0; i < 4; i++) send_op(lgtr_pkg::OP_LOAD, 5, 7, i, 0);
    send_op(lgtr_pkg::OP_LOAD, 4095, 8191, 31, 65535);
    send_op(lgtr_pkg::OP_LOAD, 0, 0, 0, 0);
    send_op(lgtr_pkg::OP_LOAD, 5, 9, 2, 0);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 3, 0);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 1, 65535);
    send_op(lgtr_pkg::OP_RESAMPLE, 4095, 8191, 31, 32768);
    send_op(lgtr_pkg::OP_RESAMPLE, 0, 0, 2, 12345);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 9, 2, 40000);
    send_op(lgtr_pkg::OP_RESAMPLE, 0, 8191, 0, 65535);
    send_op(lgtr_pkg::OP_RESAMPLE, 5, 7, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_req = ~hold_req;
    send_idle = 0;
    repeat (12) send_token(random_token());
  endtask

  task automatic test_pause();
    drain();
    repeat (30) send_token(random_token());
  endtask

  task automatic test_register_extremes();
    set_regs(0, 1, 0, 0);
    run_random(30, 10, 10);
    set_regs(2, 8192, 65535, 65535);
    run_random(40, 10, 10);
    set_regs(1, 16383, 1, 1);
    run_random(20, 10, 10);
    set_regs(63, 8192, 65535, 1);
    for (int i = 0; i < NTOPICS; i++) send_op(lgtr_pkg::OP_LOAD, i % 16, i % 32, i, 0);
    repeat (6) send_op(lgtr_pkg::OP_RESAMPLE, $urandom_range(15), $urandom_range(31),
      $urandom_range(31), $urandom_range(65535));
    set_regs(33, 100, 30000, 1000);
    repeat (3) send_op(lgtr_pkg::OP_RESAMPLE, $urandom_range(15), $urandom_range(31),
      $urandom_range(31), $urandom_range(65535));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    lgtr_pkg::result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: new_topic %0d status %0d",
          res_if.new_topic, res_if.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.new_topic !== want.new_topic) begin
          $error("new_topic expected %0d actual %0d", want.new_topic, res_if.new_topic);
          failures++;
        end
        if (res_if.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, res_if.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    tok_if.valid = 1'b0;
    tok_if.operation = lgtr_pkg::OP_LOAD;
    tok_if.doc_index = '0;
    tok_if.word_index = '0;
    tok_if.current_topic = '0;
    tok_if.random_fraction = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lgtr_pkg::REG_TOPICS;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_regs(4, 5000, 6554, 655);
    run_random(540, 19, 73);
    test_backpressure();
    set_regs(3, $urandom_range(1, 8192), $urandom_range(1, 65535), $urandom_range(1, 65535));
    run_random(540, 73, 19);
    test_pause();
    set_regs(6, 8192, 6554, 655);
    run_random(450, 0, 0);
    test_register_extremes();
    drain();
    repeat (100) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
